// ===== hdl/msel_pkg.sv =====
// shared types and constants for the median select block
// sequencer state codes and the result handshake between sequencer and top level
// no dependencies
`default_nettype none

package msel_pkg;

  localparam int unsigned VALUE_W = 32;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_INS  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_FIN  = 5'b01000,
    ST_OUT  = 5'b10000
  } seq_state_t;

  // sequencer to top level: load the result register this cycle
  typedef struct packed {
    logic load;
    logic ovf;
  } res_ctl_t;

endpackage

`default_nettype wire

// ===== hdl/msel_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// depends on nothing
`default_nettype none

module msel_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msel_seq.sv =====
// insertion sequencer: keeps the value store sorted and reads the median on the last beat
// uses msel_pkg; drives the ports of one msel_ram instance
`default_nettype none

module msel_seq #(
  parameter int unsigned MAX_SET_SIZE = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              sample_valid,
  output logic                                   sample_stall,
  input  wire logic signed [msel_pkg::VALUE_W-1:0] sample_value,
  input  wire logic                              is_final,
  input  wire logic                              out_busy,
  output msel_pkg::res_ctl_t                     res,
  output logic                                   wr_en,
  output logic [$clog2(MAX_SET_SIZE)-1:0]        wr_addr,
  output logic [msel_pkg::VALUE_W-1:0]           wr_data,
  output logic                                   rd_en,
  output logic [$clog2(MAX_SET_SIZE)-1:0]        rd_addr,
  input  wire logic [msel_pkg::VALUE_W-1:0]      rd_data
);

  localparam int unsigned AW = $clog2(MAX_SET_SIZE);
  localparam int unsigned CW = $clog2(MAX_SET_SIZE + 1);
  localparam logic [CW-1:0] FULL = CW'(MAX_SET_SIZE);

  msel_pkg::seq_state_t state, state_next;
  logic [CW-1:0] count, count_next;
  logic ovf, ovf_next;
  logic [AW-1:0] pos, pos_next;
  logic signed [msel_pkg::VALUE_W-1:0] value, value_next;
  logic final_flag, final_flag_next;

  assign sample_stall = (state != msel_pkg::ST_IDLE);

  always_comb begin
    state_next      = state;
    count_next      = count;
    ovf_next        = ovf;
    pos_next        = pos;
    value_next      = value;
    final_flag_next = final_flag;
    wr_en           = 1'b0;
    wr_addr         = pos;
    wr_data         = value;
    rd_en           = 1'b0;
    rd_addr         = pos - AW'(1);
    res.load        = 1'b0;
    res.ovf         = ovf;
    case (state)
      msel_pkg::ST_IDLE: begin
        if (sample_valid) begin
          value_next      = sample_value;
          final_flag_next = is_final;
          pos_next        = count[AW-1:0];
          state_next      = msel_pkg::ST_INS;
        end
      end
      msel_pkg::ST_INS: begin
        if (count == FULL) begin
          // store full, the beat is dropped
          ovf_next   = 1'b1;
          state_next = final_flag ? msel_pkg::ST_FIN : msel_pkg::ST_IDLE;
        end else if (pos == '0) begin
          wr_en      = 1'b1;
          count_next = count + CW'(1);
          state_next = final_flag ? msel_pkg::ST_FIN : msel_pkg::ST_IDLE;
        end else begin
          rd_en      = 1'b1;
          state_next = msel_pkg::ST_CMP;
        end
      end
      msel_pkg::ST_CMP: begin
        wr_en = 1'b1;
        if ($signed(rd_data) > value) begin
          // shift the larger neighbor up one slot
          wr_data    = rd_data;
          pos_next   = pos - AW'(1);
          state_next = msel_pkg::ST_INS;
        end else begin
          count_next = count + CW'(1);
          state_next = final_flag ? msel_pkg::ST_FIN : msel_pkg::ST_IDLE;
        end
      end
      msel_pkg::ST_FIN: begin
        rd_addr = AW'(count >> 1);
        if (!out_busy) begin
          rd_en      = 1'b1;
          state_next = msel_pkg::ST_OUT;
        end
      end
      msel_pkg::ST_OUT: begin
        res.load   = 1'b1;
        count_next = '0;
        ovf_next   = 1'b0;
        state_next = msel_pkg::ST_IDLE;
      end
      default: begin
        state_next = msel_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= msel_pkg::ST_IDLE;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      ovf   <= ovf_next;
    end
    pos        <= pos_next;
    value      <= value_next;
    final_flag <= final_flag_next;
  end

endmodule

`default_nettype wire

// ===== hdl/median_select_unit.sv =====
// top level of the median select block: value store, sequencer and result register
// depends on msel_pkg, msel_ram and msel_seq
`default_nettype none

// Values of a set arrive one beat at a time; the beat with is_final high closes the set
// and produces one result, the element at index count/2 of the set in ascending order
// (the upper median for an even count), plus a flag telling whether values beyond
// MAX_SET_SIZE were dropped. The store is one memory kept sorted by insertion; each new
// value walks down past the larger stored values, one read and one write per entry on
// the single read port; a beat that arrives while the store is full is dropped. The
// final beat then reads the median, first waiting while an earlier result still sits
// stalled in the result register. A finished result waits in that register, so the
// next set may start loading while it is still stalled.
module median_select_unit #(
  parameter int unsigned MAX_SET_SIZE = 256
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                sample_valid,
  output logic                                     sample_stall,
  input  wire logic signed [msel_pkg::VALUE_W-1:0] sample_value,
  input  wire logic                                is_final,
  output logic                                     median_valid,
  input  wire logic                                median_stall,
  output logic signed [msel_pkg::VALUE_W-1:0]      median_value,
  output logic                                     overflowed
);

  localparam int unsigned AW = $clog2(MAX_SET_SIZE);

  msel_pkg::res_ctl_t res;
  logic wr_en;
  logic rd_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic [msel_pkg::VALUE_W-1:0] wr_data;
  logic [msel_pkg::VALUE_W-1:0] rd_data;
  logic out_busy;

  assign out_busy = median_valid && median_stall;

  msel_ram #(
    .WIDTH(msel_pkg::VALUE_W),
    .DEPTH(MAX_SET_SIZE)
  ) u_store (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  msel_seq #(
    .MAX_SET_SIZE(MAX_SET_SIZE)
  ) u_seq (
    .clk         (clk),
    .rst         (rst),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_value(sample_value),
    .is_final    (is_final),
    .out_busy    (out_busy),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data),
    .rd_en       (rd_en),
    .rd_addr     (rd_addr),
    .rd_data     (rd_data)
  );

  // result register, loaded only when it is empty or draining this cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      median_valid <= 1'b0;
    end else if (res.load) begin
      median_valid <= 1'b1;
    end else if (!median_stall) begin
      median_valid <= 1'b0;
    end
    if (res.load) begin
      median_value <= $signed(rd_data);
      overflowed   <= res.ovf;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/msel_check.sv =====
// port level checks for median_select_unit, attached by bind
// depends on the ports of median_select_unit only
`default_nettype none

module msel_check (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        sample_valid,
  input wire logic        sample_stall,
  input wire logic        is_final,
  input wire logic        median_valid,
  input wire logic        median_stall,
  input wire logic [31:0] median_value,
  input wire logic        overflowed
);

  logic sample_beat;
  assign sample_beat = sample_valid && !sample_stall;

  // the block takes one beat and then works on it
  a_busy_after_beat: assert property (@(posedge clk) disable iff (rst)
    sample_beat |=> sample_stall)
    else $error("input not stalled after an accepted beat");

  // a beat that does not close a set cannot produce a fresh result next cycle
  a_no_result_midset: assert property (@(posedge clk) disable iff (rst)
    (sample_beat && !is_final) |=> !$rose(median_valid))
    else $error("result appeared right after a non-final beat");

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    (median_valid && median_stall) |=> median_valid)
    else $error("result dropped while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    (median_valid && median_stall) |=> ($stable(median_value) && $stable(overflowed)))
    else $error("result payload changed while stalled");

endmodule

bind median_select_unit msel_check u_msel_check (
  .clk         (clk),
  .rst         (rst),
  .sample_valid(sample_valid),
  .sample_stall(sample_stall),
  .is_final    (is_final),
  .median_valid(median_valid),
  .median_stall(median_stall),
  .median_value(median_value),
  .overflowed  (overflowed)
);

`default_nettype wire
